// File: hw/rtl/gsrq_pkg.sv
// Shared types and constants for the grid same-region query block.
// Holds the datapath operation codes and the status bundle passed from the
// datapath to the controller. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gsrq_pkg;

	localparam int MAX_ROWS   = 64;
	localparam int MAX_COLS   = 64;
	localparam int MAX_LABELS = 1024;
	localparam int ROW_AW     = $clog2(MAX_ROWS);
	localparam int COL_AW     = $clog2(MAX_COLS);
	localparam int LBL_W      = $clog2(MAX_LABELS);
	localparam int CNT_W      = LBL_W + 1;
	localparam int DIM_W      = 7;

	// Input command codes.
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_MARK  = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_WALL  = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_ROWS = 1'b0;
	localparam logic CFG_COLS = 1'b1;

	// Operations the controller asks of the datapath, one per cycle.
	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_CLR_ROW,
		OP_RD_WALL_A,
		OP_RD_WALL_B,
		OP_MARK_WR,
		OP_RES_RANGE,
		OP_RES_WALL,
		OP_PASS_START,
		OP_ROW_RD,
		OP_ROW_LOAD,
		OP_LB_RD,
		OP_CELL_ASSIGN,
		OP_NEXT_CELL,
		OP_WALK_X,
		OP_WALK_LA,
		OP_T_RD,
		OP_WALK_STEP,
		OP_SAVE_RA_J,
		OP_SAVE_RA_Q,
		OP_JOIN_WR,
		OP_RES_CMP,
		OP_OUT_PUSH
	} dp_op_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic [1:0] cmd;
		logic       grid_a;
		logic       grid_b;
		logic       sweep_last;
		logic       wall_a;
		logic       wall_b;
		logic       cell_wall;
		logic       up;
		logic       left;
		logic       last_col;
		logic       last_row;
		logic       walk_more;
		logic       out_busy;
	} dp_stat_t;

	// A register value of 0 reads as 1, values above the maximum saturate.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
		input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] x;
		x = v;
		if (x == '0)
			x = DIM_W'(1);
		if (x > maxv)
			x = maxv;
		return x;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/gsrq_datapath.sv
// Datapath of the grid same-region query: wall map, label line buffer,
// equivalence table, scan counters, root walk and the result register.
// Depends on gsrq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsrq_datapath import gsrq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_op_t            op,
	input  wire logic [31:0]       in_data,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [DIM_W-1:0]  cfg_data,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic [7:0]             out_data,
	output dp_stat_t               st
);

	// Configuration.
	logic [DIM_W-1:0] rows_q, cols_q;
	// Captured transaction fields.
	logic [1:0]       cmd_q;
	logic [DIM_W-1:0] r_q, c_q, r2_q, c2_q;
	// Scan state.
	logic [ROW_AW-1:0] i_q;
	logic [COL_AW-1:0] j_q;
	logic [MAX_COLS-1:0] cur_row_q, prev_row_q, wall_rd_q;
	logic [LBL_W-1:0] left_lbl_q, lb_rd_q, jx_q, jy_q, la_q, lb_q;
	logic [CNT_W-1:0] next_q;
	logic [LBL_W-1:0] w_q, ra_q, tbl_q;
	logic             wall_a_q;
	logic             res_same_q, out_same_q;
	logic [1:0]       res_stat_q, out_stat_q;
	logic             out_valid_q;

	logic [MAX_COLS-1:0] wall_mem [MAX_ROWS];
	logic [LBL_W-1:0]    line_mem [MAX_COLS];
	logic [LBL_W-1:0]    tbl_mem  [MAX_LABELS];

	logic [COL_AW-1:0] ca, cb;
	logic [ROW_AW-1:0] wall_addr;
	logic              wall_we;
	logic [MAX_COLS-1:0] wall_wdata;
	logic [LBL_W-1:0]  tbl_addr, tbl_wdata, fresh_lbl, cell_lbl;
	logic              tbl_we, sat, up, left, is_a, is_b;

	assign ca = COL_AW'(c_q - DIM_W'(1));
	assign cb = COL_AW'(c2_q - DIM_W'(1));

	// Neighbor tests and label choice for the current cell.
	assign up        = (i_q != '0) && !prev_row_q[j_q];
	assign left      = (j_q != '0) && !cur_row_q[COL_AW'(j_q - COL_AW'(1))];
	assign sat       = (next_q >= CNT_W'(MAX_LABELS));
	assign fresh_lbl = sat ? LBL_W'(MAX_LABELS - 1) : next_q[LBL_W-1:0];
	assign cell_lbl  = up ? lb_rd_q : (left ? left_lbl_q : fresh_lbl);
	assign is_a = ({1'b0, i_q} == r_q - DIM_W'(1)) && ({1'b0, j_q} == c_q - DIM_W'(1));
	assign is_b = ({1'b0, i_q} == r2_q - DIM_W'(1)) && ({1'b0, j_q} == c2_q - DIM_W'(1));

	// Wall memory port selection.
	always_comb begin
		wall_we    = 1'b0;
		wall_wdata = wall_rd_q;
		wall_addr  = i_q;
		case (op)
			OP_CLR_ROW: begin
				wall_we    = 1'b1;
				wall_wdata = '0;
			end
			OP_RD_WALL_A: wall_addr = ROW_AW'(r_q - DIM_W'(1));
			OP_RD_WALL_B: wall_addr = ROW_AW'(r2_q - DIM_W'(1));
			OP_MARK_WR: begin
				wall_addr  = ROW_AW'(r_q - DIM_W'(1));
				wall_we    = 1'b1;
				wall_wdata = wall_rd_q | (MAX_COLS'(1) << ca);
			end
			default: wall_addr = i_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wall_we)
			wall_mem[wall_addr] <= wall_wdata;
		wall_rd_q <= wall_mem[wall_addr];
	end

	// Line buffer holds the labels of the row above.
	always_ff @(posedge clk) begin
		if (op == OP_CELL_ASSIGN)
			line_mem[j_q] <= cell_lbl;
		lb_rd_q <= line_mem[j_q];
	end

	// Equivalence table port selection.
	always_comb begin
		tbl_we    = 1'b0;
		tbl_addr  = w_q;
		tbl_wdata = fresh_lbl;
		case (op)
			OP_CELL_ASSIGN: begin
				tbl_addr = fresh_lbl;
				tbl_we   = !up && !left && !sat;
			end
			OP_JOIN_WR: begin
				tbl_we    = (ra_q != w_q);
				tbl_addr  = (ra_q < w_q) ? w_q : ra_q;
				tbl_wdata = (ra_q < w_q) ? ra_q : w_q;
			end
			default: tbl_addr = w_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (tbl_we)
			tbl_mem[tbl_addr] <= tbl_wdata;
		tbl_q <= tbl_mem[tbl_addr];
	end

	// Payload registers of the scan and the root walk.
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				cmd_q <= in_data[1:0];
				r_q   <= in_data[8:2];
				c_q   <= in_data[15:9];
				r2_q  <= in_data[22:16];
				c2_q  <= in_data[29:23];
			end
			OP_RD_WALL_B:   wall_a_q <= wall_rd_q[ca];
			OP_RES_RANGE: begin
				res_same_q <= 1'b0;
				res_stat_q <= STAT_RANGE;
			end
			OP_RES_WALL: begin
				res_same_q <= 1'b0;
				res_stat_q <= STAT_WALL;
			end
			OP_PASS_START:  prev_row_q <= '1;
			OP_ROW_LOAD:    cur_row_q <= wall_rd_q;
			OP_CELL_ASSIGN: begin
				left_lbl_q <= cell_lbl;
				jx_q       <= lb_rd_q;
				jy_q       <= left_lbl_q;
				if (is_a)
					la_q <= cell_lbl;
				if (is_b)
					lb_q <= cell_lbl;
			end
			OP_NEXT_CELL: begin
				if ({1'b0, j_q} == cols_q - DIM_W'(1))
					prev_row_q <= cur_row_q;
			end
			OP_WALK_X:      w_q <= jx_q;
			OP_WALK_LA:     w_q <= la_q;
			OP_WALK_STEP:   w_q <= tbl_q;
			OP_SAVE_RA_J: begin
				ra_q <= w_q;
				w_q  <= jy_q;
			end
			OP_SAVE_RA_Q: begin
				ra_q <= w_q;
				w_q  <= lb_q;
			end
			OP_RES_CMP: begin
				res_same_q <= (ra_q == w_q);
				res_stat_q <= STAT_OK;
			end
			default: ;
		endcase
	end

	// Control registers: configuration, counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= DIM_W'(MAX_ROWS);
			cols_q      <= DIM_W'(MAX_COLS);
			i_q         <= '0;
			j_q         <= '0;
			next_q      <= '0;
			out_valid_q <= 1'b0;
			out_same_q  <= 1'b0;
			out_stat_q  <= STAT_OK;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROWS)
					rows_q <= clamp_dim(cfg_data, DIM_W'(MAX_ROWS));
				else
					cols_q <= clamp_dim(cfg_data, DIM_W'(MAX_COLS));
			end
			case (op)
				OP_LOAD:    i_q <= '0;
				OP_CLR_ROW: i_q <= ROW_AW'(i_q + ROW_AW'(1));
				OP_PASS_START: begin
					i_q    <= '0;
					j_q    <= '0;
					next_q <= '0;
				end
				OP_CELL_ASSIGN: begin
					if (!up && !left && !sat)
						next_q <= CNT_W'(next_q + CNT_W'(1));
				end
				OP_NEXT_CELL: begin
					if ({1'b0, j_q} == cols_q - DIM_W'(1)) begin
						j_q <= '0;
						i_q <= ROW_AW'(i_q + ROW_AW'(1));
					end else begin
						j_q <= COL_AW'(j_q + COL_AW'(1));
					end
				end
				default: ;
			endcase
			// A push refills the output register even as the old result leaves.
			if (op == OP_OUT_PUSH) begin
				out_valid_q <= 1'b1;
				out_same_q  <= res_same_q;
				out_stat_q  <= res_stat_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {5'b0, out_stat_q, out_same_q};

	// Status toward the controller.
	always_comb begin
		st.cmd        = cmd_q;
		st.grid_a     = (r_q != '0) && (r_q <= rows_q) && (c_q != '0) && (c_q <= cols_q);
		st.grid_b     = (r2_q != '0) && (r2_q <= rows_q) && (c2_q != '0) && (c2_q <= cols_q);
		st.sweep_last = (i_q == ROW_AW'(MAX_ROWS - 1));
		st.wall_a     = wall_a_q;
		st.wall_b     = wall_rd_q[cb];
		st.cell_wall  = cur_row_q[j_q];
		st.up         = up;
		st.left       = left;
		st.last_col   = ({1'b0, j_q} == cols_q - DIM_W'(1));
		st.last_row   = ({1'b0, i_q} == rows_q - DIM_W'(1));
		st.walk_more  = (tbl_q < w_q);
		st.out_busy   = out_valid_q && !out_ready;
	end

`ifndef SYNTHESIS
	// A merge never links a label that has not been handed out yet.
	a_join_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_JOIN_WR && tbl_we) |-> ({1'b0, tbl_addr} < next_q))
		else $error("join writes beyond allocated labels");
	// Each step of a root walk moves to a strictly smaller label.
	a_walk_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_WALK_STEP) |-> (tbl_q < w_q))
		else $error("root walk does not descend");
	// Only free cells receive a label.
	a_assign_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_CELL_ASSIGN) |-> !cur_row_q[j_q])
		else $error("label assigned to a wall cell");
	// A pushed result is presented on the next cycle.
	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_OUT_PUSH) |=> out_valid_q)
		else $error("pushed result not visible");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/gsrq_ctrl.sv
// Controller of the grid same-region query: sequences clears, marks and the
// two-pass labeling of a query through datapath operations.
// Depends on gsrq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gsrq_ctrl import gsrq_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	input  wire dp_stat_t st,
	output logic          in_ready,
	output dp_op_t        op
);

	typedef enum logic [4:0] {
		S_INIT_CLR, S_IDLE, S_DECODE, S_CLR, S_MARK, S_CHK_B, S_CHK_W,
		S_ROW, S_ROW_LD, S_CELL_RD, S_CELL, S_NEXT, S_JX, S_JRD, S_JCHK,
		S_FIN, S_OUT
	} state_t;

	typedef enum logic [1:0] {PH_JA, PH_JB, PH_QA, PH_QB} phase_t;

	state_t state_q, state_d;
	phase_t ph_q, ph_d;

	assign in_ready = (state_q == S_IDLE);

	// Next state and the operation of this cycle.
	always_comb begin
		state_d = state_q;
		ph_d    = ph_q;
		op      = OP_NOP;
		unique case (state_q)
			S_INIT_CLR, S_CLR: begin
				op = OP_CLR_ROW;
				if (st.sweep_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (st.cmd)
					CMD_CLEAR: state_d = S_CLR;
					CMD_MARK: begin
						if (st.grid_a) begin
							op      = OP_RD_WALL_A;
							state_d = S_MARK;
						end else begin
							state_d = S_IDLE;
						end
					end
					CMD_QUERY: begin
						if (st.grid_a && st.grid_b) begin
							op      = OP_RD_WALL_A;
							state_d = S_CHK_B;
						end else begin
							op      = OP_RES_RANGE;
							state_d = S_OUT;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_MARK: begin
				op      = OP_MARK_WR;
				state_d = S_IDLE;
			end
			S_CHK_B: begin
				op      = OP_RD_WALL_B;
				state_d = S_CHK_W;
			end
			S_CHK_W: begin
				if (st.wall_a || st.wall_b) begin
					op      = OP_RES_WALL;
					state_d = S_OUT;
				end else begin
					op      = OP_PASS_START;
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				op      = OP_ROW_RD;
				state_d = S_ROW_LD;
			end
			S_ROW_LD: begin
				op      = OP_ROW_LOAD;
				state_d = S_CELL_RD;
			end
			S_CELL_RD: begin
				op      = OP_LB_RD;
				state_d = S_CELL;
			end
			S_CELL: begin
				if (st.cell_wall) begin
					state_d = S_NEXT;
				end else begin
					op      = OP_CELL_ASSIGN;
					state_d = (st.up && st.left) ? S_JX : S_NEXT;
				end
			end
			S_NEXT: begin
				op = OP_NEXT_CELL;
				if (st.last_col && st.last_row)
					state_d = S_FIN;
				else if (st.last_col)
					state_d = S_ROW;
				else
					state_d = S_CELL_RD;
			end
			S_JX: begin
				op      = OP_WALK_X;
				ph_d    = PH_JA;
				state_d = S_JRD;
			end
			S_FIN: begin
				op      = OP_WALK_LA;
				ph_d    = PH_QA;
				state_d = S_JRD;
			end
			S_JRD: begin
				op      = OP_T_RD;
				state_d = S_JCHK;
			end
			S_JCHK: begin
				if (st.walk_more) begin
					op      = OP_WALK_STEP;
					state_d = S_JRD;
				end else begin
					unique case (ph_q)
						PH_JA: begin
							op      = OP_SAVE_RA_J;
							ph_d    = PH_JB;
							state_d = S_JRD;
						end
						PH_JB: begin
							op      = OP_JOIN_WR;
							state_d = S_NEXT;
						end
						PH_QA: begin
							op      = OP_SAVE_RA_Q;
							ph_d    = PH_QB;
							state_d = S_JRD;
						end
						PH_QB: begin
							op      = OP_RES_CMP;
							state_d = S_OUT;
						end
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_OUT: begin
				if (!st.out_busy) begin
					op      = OP_OUT_PUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT_CLR;
			ph_q    <= PH_JA;
		end else begin
			state_q <= state_d;
			ph_q    <= ph_d;
		end
	end

`ifndef SYNTHESIS
	// The final root walks are entered only straight from the scan's next-cell step.
	a_fin_from_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |-> $past(state_q == S_NEXT))
		else $error("final walk entered out of order");
	// Results are pushed only while the output register is free to take them.
	a_push_state: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_OUT_PUSH) |-> !st.out_busy)
		else $error("push over a waiting result");
	// A merge write closes the second walk of a join.
	a_join_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_JOIN_WR) |-> (ph_q == PH_JB))
		else $error("merge outside its phase");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/grid_same_region_query.sv
// Grid same-region query: keeps a wall map and answers whether two free
// cells share a 4-connected region. A clear sweeps every row of the wall map,
// a mark reads and rewrites one row, and a rejected query waits only for the
// output; a labeled query scans each row and cell, joins the labels of a cell
// whose upper and left neighbors are free, and walks each label to its root.
// One transaction at a time; a finished result waits in the output register.
// After reset every row of the wall map is swept clear before input is taken.
`timescale 1ns / 1ps
`default_nettype none
module grid_same_region_query import gsrq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// command[1:0], row[8:2], col[15:9], other_row[22:16], other_col[29:23], zeros
	input  wire logic [31:0]       s_tdata,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// same_region[0], status[2:1], zeros
	output logic [7:0]             m_tdata,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [DIM_W-1:0]  cfg_data
);

	dp_op_t   op;
	dp_stat_t st;

	gsrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.st       (st),
		.in_ready (s_tready),
		.op       (op)
	);

	gsrq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.st        (st)
	);

endmodule
`default_nettype wire
